// ----- hw/rtl/pstc_pkg.sv -----
package pstc_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int PROD_W = 16 + ENT_W;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [ENT_W-1:0] LAST_PROBE = ENT_W'(TABLE_ENTRIES - 1);

   localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
   localparam logic [15:0] ETH_IP_HDR_BYTES = 16'd34;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0] PROTO_TCP = 8'd6;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
   } key_word_type;

   typedef struct packed {
      logic             rd;
      logic [IDX_W-1:0] rd_addr;
      logic             wr;
      logic [IDX_W-1:0] wr_addr;
      logic [31:0]      wr_key;
   } key_cmd_type;

   typedef struct packed {
      logic [63:0] packets;
      logic [63:0] bytes;
   } count_word_type;

   typedef struct packed {
      logic             load;
      logic             init;
      logic             bump;
      logic [IDX_W-1:0] addr;
      logic [15:0]      len;
   } cnt_cmd_type;

   typedef struct packed {
      logic        verdict;
      logic        counted;
      logic        inserted;
      logic        table_full;
      logic [63:0] packet_total;
      logic [63:0] byte_total;
   } rsp_beat_type;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [31:0] src_address;
      logic [15:0] frame_length;
   } req_beat_type;

   // home slot: byte-swapped fold, scaled into the table range
   function automatic logic [IDX_W-1:0] slot_hash(input logic [31:0] key);
      logic [15:0]       fold;
      logic [PROD_W-1:0] prod;
      fold = {key[7:0], key[15:8]} ^ key[31:16];
      prod = PROD_W'(fold) * PROD_W'(TABLE_ENTRIES);
      return prod[16 +: IDX_W];
   endfunction

endpackage

// ----- hw/rtl/pstc_req_if.sv -----
interface pstc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] ether_type;
   logic [7:0]  ip_protocol;
   logic [31:0] src_address;
   logic [15:0] frame_length;

   modport source (
      output valid, ether_type, ip_protocol, src_address, frame_length,
      input  ready
   );
   modport sink (
      input  valid, ether_type, ip_protocol, src_address, frame_length,
      output ready
   );
endinterface

// ----- hw/rtl/pstc_rsp_if.sv -----
interface pstc_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict;
   logic        counted;
   logic        inserted;
   logic        table_full;
   logic [63:0] packet_total;
   logic [63:0] byte_total;

   modport source (
      output valid, verdict, counted, inserted, table_full, packet_total, byte_total,
      input  ready
   );
   modport sink (
      input  valid, verdict, counted, inserted, table_full, packet_total, byte_total,
      output ready
   );
endinterface

// ----- hw/rtl/pstc_key_table.sv -----
module pstc_key_table import pstc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  key_cmd_type  cmd,
   output key_word_type rd_word,
   output logic         busy
);

   key_word_type     key_mem_ff [TABLE_ENTRIES];
   key_word_type     rd_word_ff;
   logic             clearing_ff;
   logic             clearing_in;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [IDX_W-1:0] clr_idx_in;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   key_word_type     wr_word;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in = clr_idx_ff;
      if (clearing_ff) begin
         if (clr_idx_ff == LAST_SLOT) begin
            clearing_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         wr_en = 1'b1;
         wr_addr = clr_idx_ff;
         wr_word = '{valid: 1'b0, key: 32'd0};
      end else begin
         wr_en = cmd.wr;
         wr_addr = cmd.wr_addr;
         wr_word = '{valid: 1'b1, key: cmd.wr_key};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_word;
      end
      if (cmd.rd) begin
         rd_word_ff <= key_mem_ff[cmd.rd_addr];
      end
   end

   assign rd_word = rd_word_ff;
   assign busy = clearing_ff;

endmodule

// ----- hw/rtl/pstc_count_table.sv -----
module pstc_count_table import pstc_pkg::*; (
   input  logic           clock,
   input  cnt_cmd_type    cmd,
   output count_word_type sum
);

   count_word_type cnt_mem_ff [TABLE_ENTRIES];
   count_word_type rd_word_ff;
   count_word_type wr_word;

   // totals after this beat, from the count word registered by the last load
   assign sum.packets = rd_word_ff.packets + 64'd1;
   assign sum.bytes = rd_word_ff.bytes + {48'd0, cmd.len};

   always_comb begin
      if (cmd.init) begin
         wr_word = '{packets: 64'd1, bytes: {48'd0, cmd.len}};
      end else begin
         wr_word = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init || cmd.bump) begin
         cnt_mem_ff[cmd.addr] <= wr_word;
      end
      if (cmd.load) begin
         rd_word_ff <= cnt_mem_ff[cmd.addr];
      end
   end

endmodule

// ----- hw/rtl/pstc_ctrl.sv -----
module pstc_ctrl import pstc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   pstc_req_if.sink       req_chan,
   pstc_rsp_if.source     rsp_chan,
   input  key_word_type   key_word,
   input  logic           key_busy,
   input  count_word_type cnt_sum,
   output key_cmd_type    key_cmd,
   output cnt_cmd_type    cnt_cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PROBE  = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   req_beat_type     item_ff, item_in;
   logic [IDX_W-1:0] probe_idx_ff, probe_idx_in;
   logic [ENT_W-1:0] probe_cnt_ff, probe_cnt_in;
   rsp_beat_type     res_ff, res_in;
   rsp_beat_type     rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             slot_free;
   logic             done;
   rsp_beat_type     res_next;
   logic [IDX_W-1:0] home_slot;
   logic [IDX_W-1:0] next_slot;

   assign req_chan.ready = (state_ff == ST_IDLE) && !key_busy;
   assign accept = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign home_slot = slot_hash(req_chan.src_address);
   assign next_slot = (probe_idx_ff == LAST_SLOT) ? '0 : probe_idx_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      probe_idx_in = probe_idx_ff;
      probe_cnt_in = probe_cnt_ff;
      res_in = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      done = 1'b0;
      res_next = '0;
      key_cmd = '0;
      cnt_cmd = '0;
      cnt_cmd.addr = probe_idx_ff;
      cnt_cmd.len = item_ff.frame_length;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in.ether_type = req_chan.ether_type;
               item_in.ip_protocol = req_chan.ip_protocol;
               item_in.src_address = req_chan.src_address;
               item_in.frame_length = req_chan.frame_length;
               probe_idx_in = home_slot;
               probe_cnt_in = '0;
               key_cmd.rd = 1'b1;
               key_cmd.rd_addr = home_slot;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            priority if (item_ff.frame_length < ETH_HDR_BYTES) begin
               done = 1'b1;
               res_next.verdict = 1'b1;
            end else if (item_ff.ether_type != ETYPE_IPV4) begin
               done = 1'b1;
            end else if (item_ff.frame_length < ETH_IP_HDR_BYTES) begin
               done = 1'b1;
               res_next.verdict = 1'b1;
            end else if (item_ff.ip_protocol != PROTO_TCP) begin
               done = 1'b1;
            end else if (key_word.valid && key_word.key == item_ff.src_address) begin
               cnt_cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end else if (!key_word.valid) begin
               // empty slot ends the chain: the source is new
               key_cmd.wr = 1'b1;
               key_cmd.wr_addr = probe_idx_ff;
               key_cmd.wr_key = item_ff.src_address;
               cnt_cmd.init = 1'b1;
               done = 1'b1;
               res_next.counted = 1'b1;
               res_next.inserted = 1'b1;
               res_next.packet_total = 64'd1;
               res_next.byte_total = {48'd0, item_ff.frame_length};
            end else if (probe_cnt_ff == LAST_PROBE) begin
               done = 1'b1;
               res_next.table_full = 1'b1;
            end else begin
               probe_idx_in = next_slot;
               probe_cnt_in = probe_cnt_ff + 1'b1;
               key_cmd.rd = 1'b1;
               key_cmd.rd_addr = next_slot;
            end
         end
         ST_UPDATE: begin
            cnt_cmd.bump = 1'b1;
            done = 1'b1;
            res_next.counted = 1'b1;
            res_next.packet_total = cnt_sum.packets;
            res_next.byte_total = cnt_sum.bytes;
         end
         ST_FINISH: begin
            done = 1'b1;
            res_next = res_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         if (slot_free) begin
            rsp_data_in = res_next;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end else begin
            res_in = res_next;
            state_in = ST_FINISH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      probe_idx_ff <= probe_idx_in;
      probe_cnt_ff <= probe_cnt_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.verdict = rsp_data_ff.verdict;
   assign rsp_chan.counted = rsp_data_ff.counted;
   assign rsp_chan.inserted = rsp_data_ff.inserted;
   assign rsp_chan.table_full = rsp_data_ff.table_full;
   assign rsp_chan.packet_total = rsp_data_ff.packet_total;
   assign rsp_chan.byte_total = rsp_data_ff.byte_total;

endmodule

// ----- hw/rtl/per_source_tcp_packet_counter_top.sv -----
// per-source tcp packet and byte counter
// req_chan: one frame descriptor per beat (ethertype, ip protocol, source
//   address, frame length); rsp_chan: exactly one result beat per request
// short frames are dropped, non-ipv4 and non-tcp frames pass uncounted,
//   tcp frames update or create a per-source entry with 64-bit totals, or flag table_full
// entries live in a hashed, linearly probed table of TABLE_ENTRIES slots:
//   a key memory (valid + address) and a count memory, both with registered reads
// result path: the key read is registered on accept; uncounted frames
//   and a home-slot insert finish in ST_PROBE, a home-slot hit adds
//   ST_UPDATE, extra probes repeat ST_PROBE; a full table probes every slot
// flow: one item at a time, next beat taken the cycle after the
//   result is registered; the probe loop over the key memory read port sets
//   how long each item takes
// reset: after reset the key memory is cleared one slot per cycle, all
//   TABLE_ENTRIES slots, with req_chan.ready low
// a stalled rsp_chan holds its beat; the next request is still accepted and
//   processed, and its result waits in a second register until the first drains
module per_source_tcp_packet_counter_top import pstc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pstc_req_if.sink   req_chan,
   pstc_rsp_if.source rsp_chan
);

   key_cmd_type    key_cmd;
   key_word_type   key_word;
   logic           key_busy;
   cnt_cmd_type    cnt_cmd;
   count_word_type cnt_sum;

   pstc_key_table u_key_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (key_cmd),
      .rd_word (key_word),
      .busy    (key_busy)
   );

   pstc_count_table u_count_table (
      .clock (clock),
      .cmd   (cnt_cmd),
      .sum   (cnt_sum)
   );

   pstc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .key_word (key_word),
      .key_busy (key_busy),
      .cnt_sum  (cnt_sum),
      .key_cmd  (key_cmd),
      .cnt_cmd  (cnt_cmd)
   );

`ifndef SYNTH
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      key_busy |-> !req_chan.ready)
      else $error("request taken during key memory clear");

   a_bump_after_load: assert property (@(posedge clock) disable iff (reset)
      cnt_cmd.bump |-> $past(cnt_cmd.load) && ($past(cnt_cmd.addr) == cnt_cmd.addr))
      else $error("count write-back without matching read");

   a_insert_pairs_init: assert property (@(posedge clock) disable iff (reset)
      key_cmd.wr |-> cnt_cmd.init && (cnt_cmd.addr == key_cmd.wr_addr))
      else $error("key insert without count init at same slot");

   a_accept_reads_key: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> key_cmd.rd && !key_cmd.wr)
      else $error("accepted beat did not start a key probe");
`endif

endmodule
